@@ design/bvm_pkg.sv @@
// Shared types, constants and decode codes for the byte VM instruction executor.
`timescale 1ns / 1ps

package bvm_pkg;

    localparam int STACK_DEPTH  = 16;
    localparam int NUM_REGS     = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam int REG_IDX_W    = $clog2(NUM_REGS);
    localparam int STACK_CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int STACK_OUT_W  = 5;
    localparam int Q_PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [11:0] PC_RESET  = 12'h200;
    localparam logic [11:0] PC_STEP   = 12'd2;
    localparam logic [11:0] PC_SKIP   = 12'd4;
    localparam logic [REG_IDX_W-1:0] FLAG_REG = REG_IDX_W'(NUM_REGS - 1);
    localparam logic [REG_IDX_W-1:0] ZERO_REG = '0;

    // Opcode nibbles
    localparam logic [3:0] OP_JP      = 4'h1;
    localparam logic [3:0] OP_CALL    = 4'h2;
    localparam logic [3:0] OP_SE_IMM  = 4'h3;
    localparam logic [3:0] OP_SNE_IMM = 4'h4;
    localparam logic [3:0] OP_SE_REG  = 4'h5;
    localparam logic [3:0] OP_LD_IMM  = 4'h6;
    localparam logic [3:0] OP_ADD_IMM = 4'h7;
    localparam logic [3:0] OP_ALU     = 4'h8;
    localparam logic [3:0] OP_SNE_REG = 4'h9;
    localparam logic [3:0] OP_LD_I    = 4'hA;
    localparam logic [3:0] OP_JP_V0   = 4'hB;
    localparam logic [3:0] OP_RND     = 4'hC;

    // ALU sub-operations (low nibble of 8xyN)
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // Instruction classes produced by the front end
    localparam logic [3:0] K_BAD     = 4'd0;
    localparam logic [3:0] K_JP      = 4'd1;
    localparam logic [3:0] K_CALL    = 4'd2;
    localparam logic [3:0] K_SE_IMM  = 4'd3;
    localparam logic [3:0] K_SNE_IMM = 4'd4;
    localparam logic [3:0] K_SE_REG  = 4'd5;
    localparam logic [3:0] K_SNE_REG = 4'd6;
    localparam logic [3:0] K_LD_IMM  = 4'd7;
    localparam logic [3:0] K_ADD_IMM = 4'd8;
    localparam logic [3:0] K_ALU     = 4'd9;
    localparam logic [3:0] K_LD_I    = 4'd10;
    localparam logic [3:0] K_JP_V0   = 4'd11;
    localparam logic [3:0] K_RND     = 4'd12;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef logic [3:0] kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [REG_IDX_W-1:0] x;
        logic [REG_IDX_W-1:0] y;
        logic [3:0]           alu;
        logic [7:0]           kk;
        logic [11:0]          nnn;
        logic [7:0]           rnd;
    } dec_t;

    typedef struct packed {
        logic [11:0]            next_pc;
        logic [11:0]            index_value;
        logic [3:0]             written_reg;
        logic [7:0]             written_value;
        logic                   reg_written;
        logic [7:0]             flag_value;
        logic [STACK_OUT_W-1:0] stack_depth;
        logic [1:0]             status;
    } res_t;

endpackage

@@ design/bvm_if.sv @@
// Valid/ready channel interfaces for instruction and result transfers.
`timescale 1ns / 1ps

interface bvm_in_if;
    import bvm_pkg::*;

    logic        valid;
    logic        ready;
    logic [15:0] instr_word;
    logic [7:0]  random_byte;

    modport source (output valid, output instr_word, output random_byte, input ready);
    modport sink   (input valid, input instr_word, input random_byte, output ready);
endinterface

interface bvm_out_if;
    import bvm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [11:0]            next_pc;
    logic [11:0]            index_value;
    logic [3:0]             written_reg;
    logic [7:0]             written_value;
    logic                   reg_written;
    logic [7:0]             flag_value;
    logic [STACK_OUT_W-1:0] stack_depth;
    logic [1:0]             status;

    modport source (
        output valid, input ready,
        output next_pc, output index_value, output written_reg, output written_value,
        output reg_written, output flag_value, output stack_depth, output status
    );
    modport sink (
        input valid, output ready,
        input next_pc, input index_value, input written_reg, input written_value,
        input reg_written, input flag_value, input stack_depth, input status
    );
endinterface

@@ design/byte_vm_instruction_execute_top.sv @@
// Top level of the byte VM instruction executor.
// Executes one 16-bit CHIP-8 instruction per transfer and returns one result per
// instruction. Throughput is one instruction per cycle while the result channel is not
// stalled. An instruction is decoded into a two-entry queue at the transfer, read from
// the register file, then executed into the result register. The execute stage sets
// the rate: it reads Vx and Vy from a register file with two registered read ports
// and forwards the previous instruction's write, so dependent instructions issue
// back to back. VF and a copy of V0 sit in flops. The call stack
// keeps only its depth.
`timescale 1ns / 1ps

module byte_vm_instruction_execute_top (
    input  logic      clk,
    input  logic      rst_n,
    bvm_in_if.sink    in_ch,
    bvm_out_if.source out_ch
);
    import bvm_pkg::*;

    logic q_push_valid;
    logic q_push_ready;
    dec_t q_push_data;
    logic q_pop_valid;
    logic q_pop_ready;
    dec_t q_pop_data;

    bvm_front u_front (
        .in_ch   (in_ch),
        .q_ready (q_push_ready),
        .q_valid (q_push_valid),
        .q_data  (q_push_data)
    );

    bvm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_data   (q_pop_data),
        .pop_ready  (q_pop_ready)
    );

    bvm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_pop_valid),
        .q_data  (q_pop_data),
        .q_ready (q_pop_ready),
        .out_ch  (out_ch)
    );

`ifndef SYNTHESIS
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status == ST_OVF))
            |-> (out_ch.stack_depth == STACK_OUT_W'(STACK_DEPTH)))
        else $error("overflow reported with stack not full");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.reg_written) |-> (out_ch.status == ST_OK))
        else $error("register written by a rejected instruction");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.reg_written)
            |-> ((out_ch.written_reg == 4'd0) && (out_ch.written_value == 8'd0)))
        else $error("write fields nonzero without a register write");

    a_flag_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.reg_written && (out_ch.written_reg == 4'hF))
            |-> (out_ch.flag_value == out_ch.written_value))
        else $error("VF does not match its own write");
`endif

endmodule

@@ design/bvm_ram.sv @@
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module bvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ design/bvm_front.sv @@
// Front end: accept instruction transfers and classify them.
`timescale 1ns / 1ps

module bvm_front (
    bvm_in_if.sink       in_ch,
    input  logic         q_ready,
    output logic         q_valid,
    output bvm_pkg::dec_t q_data
);
    import bvm_pkg::*;

    logic [3:0] op;
    logic [3:0] n;
    kind_t      kind;

    assign op = in_ch.instr_word[15:12];
    assign n  = in_ch.instr_word[3:0];

    always_comb
    begin
        case (op)
            OP_JP:      kind = K_JP;
            OP_CALL:    kind = K_CALL;
            OP_SE_IMM:  kind = K_SE_IMM;
            OP_SNE_IMM: kind = K_SNE_IMM;
            OP_SE_REG:  kind = (n == 4'h0) ? K_SE_REG : K_BAD;
            OP_LD_IMM:  kind = K_LD_IMM;
            OP_ADD_IMM: kind = K_ADD_IMM;
            OP_ALU:
            begin
                case (n)
                    ALU_MOV, ALU_OR, ALU_AND, ALU_XOR,
                    ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL: kind = K_ALU;
                    default:                                   kind = K_BAD;
                endcase
            end
            OP_SNE_REG: kind = (n == 4'h0) ? K_SNE_REG : K_BAD;
            OP_LD_I:    kind = K_LD_I;
            OP_JP_V0:   kind = K_JP_V0;
            OP_RND:     kind = K_RND;
            default:    kind = K_BAD;
        endcase
    end

    assign q_data.kind = kind;
    assign q_data.x    = in_ch.instr_word[11:8];
    assign q_data.y    = in_ch.instr_word[7:4];
    assign q_data.alu  = n;
    assign q_data.kk   = in_ch.instr_word[7:0];
    assign q_data.nnn  = in_ch.instr_word[11:0];
    assign q_data.rnd  = in_ch.random_byte;

    assign q_valid     = in_ch.valid;
    assign in_ch.ready = q_ready;

endmodule

@@ design/bvm_queue.sv @@
// Short FIFO between the front end and the execute stage.
`timescale 1ns / 1ps

module bvm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  bvm_pkg::dec_t push_data,
    output logic          push_ready,
    output logic          pop_valid,
    output bvm_pkg::dec_t pop_data,
    input  logic          pop_ready
);
    import bvm_pkg::*;

    localparam logic [Q_PTR_W-1:0] LAST_PTR = Q_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] FULL_CNT = Q_CNT_W'(QUEUE_DEPTH);

    dec_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/bvm_back.sv @@
// Back end: register file read, execute, state update and result register.
`timescale 1ns / 1ps

module bvm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  bvm_pkg::dec_t q_data,
    output logic          q_ready,
    bvm_out_if.source     out_ch
);
    import bvm_pkg::*;

    localparam logic [STACK_CNT_W-1:0] STACK_FULL = STACK_CNT_W'(STACK_DEPTH);

    // Execute stage
    logic                   e_valid_reg;
    dec_t                   e_reg;
    logic                   fire;
    logic                   load;

    // Architectural state
    logic [11:0]            pc_reg;
    logic [11:0]            pc_next;
    logic [11:0]            index_reg;
    logic [11:0]            index_next;
    logic [STACK_CNT_W-1:0] stack_cnt_reg;
    logic [STACK_CNT_W-1:0] stack_cnt_next;
    logic [7:0]             vf_reg;
    logic [7:0]             vf_next;
    logic [7:0]             v0_reg;
    logic [7:0]             v0_next;
    logic [NUM_REGS-1:0]    reg_vld_reg;

    // Last register file write, for forwarding
    logic                   lw_valid_reg;
    logic [REG_IDX_W-1:0]   lw_idx_reg;
    logic [7:0]             lw_val_reg;

    // Result register
    logic                   out_valid_reg;
    res_t                   out_reg;
    res_t                   res;

    logic [7:0]             rd_a;
    logic [7:0]             rd_b;
    logic [7:0]             vx;
    logic [7:0]             vy;
    logic [8:0]             sum9;
    logic                   wr;
    logic [7:0]             wval;
    logic                   flag_we;
    logic [7:0]             flag_val;
    logic [1:0]             status;
    logic [11:0]            pc_plus2;
    logic [11:0]            pc_plus4;

    assign fire    = e_valid_reg && (!out_valid_reg || out_ch.ready);
    assign q_ready = !e_valid_reg || fire;
    assign load    = q_valid && q_ready;

    bvm_ram #(
        .WIDTH (8),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .clk     (clk),
        .we      (fire && wr),
        .waddr   (e_reg.x),
        .wdata   (wval),
        .re      (load),
        .raddr_a (q_data.x),
        .raddr_b (q_data.y),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        if (e_reg.x == FLAG_REG)
        begin
            vx = vf_reg;
        end
        else if (lw_valid_reg && (lw_idx_reg == e_reg.x))
        begin
            vx = lw_val_reg;
        end
        else
        begin
            vx = reg_vld_reg[e_reg.x] ? rd_a : 8'd0;
        end

        if (e_reg.y == FLAG_REG)
        begin
            vy = vf_reg;
        end
        else if (lw_valid_reg && (lw_idx_reg == e_reg.y))
        begin
            vy = lw_val_reg;
        end
        else
        begin
            vy = reg_vld_reg[e_reg.y] ? rd_b : 8'd0;
        end
    end

    assign sum9     = {1'b0, vx} + {1'b0, vy};
    assign pc_plus2 = pc_reg + PC_STEP;
    assign pc_plus4 = pc_reg + PC_SKIP;

    always_comb
    begin
        pc_next        = pc_reg;
        index_next     = index_reg;
        stack_cnt_next = stack_cnt_reg;
        wr             = 1'b0;
        wval           = 8'd0;
        flag_we        = 1'b0;
        flag_val       = 8'd0;
        status         = ST_OK;

        case (e_reg.kind)
            K_JP:
            begin
                pc_next = e_reg.nnn;
            end
            K_CALL:
            begin
                if (stack_cnt_reg >= STACK_FULL)
                begin
                    status = ST_OVF;
                end
                else
                begin
                    stack_cnt_next = stack_cnt_reg + 1'b1;
                    pc_next        = e_reg.nnn;
                end
            end
            K_SE_IMM:  pc_next = (vx == e_reg.kk) ? pc_plus4 : pc_plus2;
            K_SNE_IMM: pc_next = (vx != e_reg.kk) ? pc_plus4 : pc_plus2;
            K_SE_REG:  pc_next = (vx == vy) ? pc_plus4 : pc_plus2;
            K_SNE_REG: pc_next = (vx != vy) ? pc_plus4 : pc_plus2;
            K_LD_IMM:
            begin
                wr      = 1'b1;
                wval    = e_reg.kk;
                pc_next = pc_plus2;
            end
            K_ADD_IMM:
            begin
                wr      = 1'b1;
                wval    = vx + e_reg.kk;
                pc_next = pc_plus2;
            end
            K_ALU:
            begin
                wr      = 1'b1;
                pc_next = pc_plus2;
                case (e_reg.alu)
                    ALU_MOV: wval = vy;
                    ALU_OR:  wval = vx | vy;
                    ALU_AND: wval = vx & vy;
                    ALU_XOR: wval = vx ^ vy;
                    ALU_ADD:
                    begin
                        wval     = sum9[7:0];
                        flag_we  = 1'b1;
                        flag_val = {7'd0, sum9[8]};
                    end
                    ALU_SUB:
                    begin
                        wval     = vx - vy;
                        flag_we  = 1'b1;
                        flag_val = {7'd0, (vx >= vy)};
                    end
                    ALU_SHR:
                    begin
                        wval     = {1'b0, vx[7:1]};
                        flag_we  = 1'b1;
                        flag_val = {7'd0, vx[0]};
                    end
                    ALU_SBN:
                    begin
                        wval     = vy - vx;
                        flag_we  = 1'b1;
                        flag_val = {7'd0, (vy >= vx)};
                    end
                    ALU_SHL:
                    begin
                        wval     = {vx[6:0], 1'b0};
                        flag_we  = 1'b1;
                        flag_val = {7'd0, vx[7]};
                    end
                    default:
                    begin
                        wr      = 1'b0;
                        pc_next = pc_reg;
                        status  = ST_BAD;
                    end
                endcase
            end
            K_LD_I:
            begin
                index_next = e_reg.nnn;
                pc_next    = pc_plus2;
            end
            K_JP_V0:
            begin
                pc_next = {4'd0, v0_reg} + e_reg.nnn;
            end
            K_RND:
            begin
                wr      = 1'b1;
                wval    = e_reg.rnd & e_reg.kk;
                pc_next = pc_plus2;
            end
            default:
            begin
                status = ST_BAD;
            end
        endcase
    end

    always_comb
    begin
        vf_next = vf_reg;
        if (wr && (e_reg.x == FLAG_REG))
        begin
            vf_next = wval;
        end
        else if (flag_we)
        begin
            vf_next = flag_val;
        end
        v0_next = (wr && (e_reg.x == ZERO_REG)) ? wval : v0_reg;
    end

    assign res.next_pc       = pc_next;
    assign res.index_value   = index_next;
    assign res.written_reg   = wr ? 4'(e_reg.x) : 4'd0;
    assign res.written_value = wr ? wval : 8'd0;
    assign res.reg_written   = wr;
    assign res.flag_value    = vf_next;
    assign res.stack_depth   = STACK_OUT_W'(stack_cnt_next);
    assign res.status        = status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= PC_RESET;
            index_reg     <= '0;
            stack_cnt_reg <= '0;
            vf_reg        <= '0;
            v0_reg        <= '0;
            reg_vld_reg   <= '0;
            lw_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                e_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                e_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                pc_reg        <= pc_next;
                index_reg     <= index_next;
                stack_cnt_reg <= stack_cnt_next;
                vf_reg        <= vf_next;
                v0_reg        <= v0_next;
                if (wr)
                begin
                    reg_vld_reg[e_reg.x] <= 1'b1;
                    lw_valid_reg         <= 1'b1;
                end
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            e_reg <= q_data;
        end
        if (fire)
        begin
            out_reg <= res;
            if (wr)
            begin
                lw_idx_reg <= e_reg.x;
                lw_val_reg <= wval;
            end
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.next_pc       = out_reg.next_pc;
    assign out_ch.index_value   = out_reg.index_value;
    assign out_ch.written_reg   = out_reg.written_reg;
    assign out_ch.written_value = out_reg.written_value;
    assign out_ch.reg_written   = out_reg.reg_written;
    assign out_ch.flag_value    = out_reg.flag_value;
    assign out_ch.stack_depth   = out_reg.stack_depth;
    assign out_ch.status        = out_reg.status;

endmodule
